// ===== rtl/tsc_pkg.sv =====
// Shared types and constants for the text statistics substring counter.
`timescale 1ns / 1ps
package tsc_pkg;

   localparam int PAT_BYTES       = 16;
   localparam int PAT_LEN_WIDTH   = 5;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int OUT_WIDTH       = 32;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [7:0] SPACE_BYTE   = 8'h20;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH = 2'd2;

   typedef struct packed {
      logic [8*PAT_BYTES-1:0]   bytes;   // byte 0 in bits 7:0
      logic [PAT_LEN_WIDTH-1:0] length;
   } pattern_type;

   typedef struct packed {
      logic letter;
      logic digit;
      logic space;
   } char_class_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type r;
      r.letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
      r.digit  = (c >= 8'h30) && (c <= 8'h39);
      r.space  = (c == SPACE_BYTE);
      return r;
   endfunction

endpackage

// ===== rtl/tsc_counter.sv =====
// Saturating event counter.
`timescale 1ns / 1ps
module tsc_counter #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             bump,
   output logic [WIDTH-1:0] count
);
   logic [WIDTH-1:0] count_ff;
   logic [WIDTH-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (bump && (count_ff != {WIDTH{1'b1}})) begin
         count_in = count_ff + WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;
endmodule

// ===== rtl/tsc_match.sv =====
// Byte window, chunk tracking and parallel pattern compare.
`timescale 1ns / 1ps
module tsc_match #(
   parameter int MAX_PATTERN = 16,
   parameter int CHUNK_LIMIT = 79
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           char_in,
   input  tsc_pkg::pattern_type pattern,
   output logic                 line_hit
);
   import tsc_pkg::*;

   localparam int CW = $clog2(CHUNK_LIMIT + 1);

   logic [7:0]              window_ff [MAX_PATTERN];
   logic [7:0]              window_in [MAX_PATTERN];
   logic [CW-1:0]           chunk_len_ff;
   logic [CW-1:0]           chunk_len_in;
   logic                    has_match_ff;
   logic                    has_match_in;
   logic [CW-1:0]           len_next;
   logic [PAT_LEN_WIDTH-1:0] pat_len;
   logic                    mismatch;
   logic                    match_here;
   logic                    chunk_end;

   always_comb begin
      window_in[0] = char_in;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // Lengths above the window size act as the window size.
   assign pat_len = (pattern.length > PAT_LEN_WIDTH'(MAX_PATTERN)) ?
                    PAT_LEN_WIDTH'(MAX_PATTERN) : pattern.length;

   assign len_next = chunk_len_ff + CW'(1);

   // Pattern byte k lines up with window slot len-1-k (newest in slot 0).
   always_comb begin
      mismatch = 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if ((j + k + 1 == int'(pat_len)) &&
                (window_in[j] != pattern.bytes[8*k +: 8])) begin
               mismatch = 1'b1;
            end
         end
      end
   end

   assign match_here = !mismatch && (8'(pat_len) <= 8'(len_next));
   assign line_hit   = accept && !has_match_ff && match_here;
   assign chunk_end  = (char_in == NEWLINE_BYTE) || (len_next >= CW'(CHUNK_LIMIT));

   always_comb begin
      chunk_len_in = chunk_len_ff;
      has_match_in = has_match_ff;
      if (accept) begin
         if (chunk_end) begin
            chunk_len_in = '0;
            has_match_in = 1'b0;
         end else begin
            chunk_len_in = len_next;
            has_match_in = has_match_ff || match_here;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_len_ff <= '0;
         has_match_ff <= 1'b0;
      end else begin
         chunk_len_ff <= chunk_len_in;
         has_match_ff <= has_match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end
endmodule

// ===== rtl/text_statistics_substring_counter_core.sv =====
// Top level of the text statistics and substring line counter.
//
//   channel | direction | handshake        | payload
//   req_    | in        | valid / stall    | character byte
//   rsp_    | out       | valid / stall    | five running counts
//   csr_    | in        | valid / ready    | register index, 64-bit data
//
// One byte per cycle while the result is not stalled: the result is registered in the cycle after the transfer.
// The count registers themselves form the result register; a new byte is taken
// whenever the result register is empty or being drained in the same cycle.
// Critical path: window shift, 16-byte compare and a 32-bit increment.
// Reset is synchronous and clears counts, chunk state and pattern registers.
// A stalled result holds; req_stall rises only while the result is stalled.
`timescale 1ns / 1ps
module text_statistics_substring_counter_core #(
   parameter int MAX_PATTERN = 16,
   parameter int CHUNK_LIMIT = 79,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_character,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tsc_pkg::OUT_WIDTH-1:0]        rsp_letter_count,
   output logic [tsc_pkg::OUT_WIDTH-1:0]        rsp_digit_count,
   output logic [tsc_pkg::OUT_WIDTH-1:0]        rsp_space_count,
   output logic [tsc_pkg::OUT_WIDTH-1:0]        rsp_total_count,
   output logic [tsc_pkg::OUT_WIDTH-1:0]        rsp_matched_lines,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tsc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tsc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import tsc_pkg::*;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [CSR_DATA_WIDTH-1:0] pat_low_ff;
   logic [CSR_DATA_WIDTH-1:0] pat_high_ff;
   logic [PAT_LEN_WIDTH-1:0]  pat_len_ff;
   pattern_type               pattern;
   char_class_type            cls;
   logic                      accept;
   logic                      line_hit;
   logic [COUNT_WIDTH-1:0]    letters;
   logic [COUNT_WIDTH-1:0]    digits;
   logic [COUNT_WIDTH-1:0]    spaces;
   logic [COUNT_WIDTH-1:0]    total;
   logic [COUNT_WIDTH-1:0]    lines;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         pat_len_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW:    pat_low_ff  <= csr_data;
               CSR_PATTERN_HIGH:   pat_high_ff <= csr_data;
               CSR_PATTERN_LENGTH: pat_len_ff  <= csr_data[PAT_LEN_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign pattern.bytes  = {pat_high_ff, pat_low_ff};
   assign pattern.length = pat_len_ff;
   assign cls            = classify(req_character);

   tsc_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .CHUNK_LIMIT (CHUNK_LIMIT)
   ) u_match (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .char_in  (req_character),
      .pattern  (pattern),
      .line_hit (line_hit)
   );

   tsc_counter #(.WIDTH(COUNT_WIDTH)) u_letters (
      .clock (clock), .reset (reset), .bump (accept && cls.letter), .count (letters)
   );
   tsc_counter #(.WIDTH(COUNT_WIDTH)) u_digits (
      .clock (clock), .reset (reset), .bump (accept && cls.digit), .count (digits)
   );
   tsc_counter #(.WIDTH(COUNT_WIDTH)) u_spaces (
      .clock (clock), .reset (reset), .bump (accept && cls.space), .count (spaces)
   );
   tsc_counter #(.WIDTH(COUNT_WIDTH)) u_total (
      .clock (clock), .reset (reset), .bump (accept), .count (total)
   );
   tsc_counter #(.WIDTH(COUNT_WIDTH)) u_lines (
      .clock (clock), .reset (reset), .bump (line_hit), .count (lines)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_letter_count  = OUT_WIDTH'(letters);
   assign rsp_digit_count   = OUT_WIDTH'(digits);
   assign rsp_space_count   = OUT_WIDTH'(spaces);
   assign rsp_total_count   = OUT_WIDTH'(total);
   assign rsp_matched_lines = OUT_WIDTH'(lines);
endmodule

// ===== rtl/tsc_checker.sv =====
// Port-level checks for the substring counter core, bound to the top level.
`timescale 1ns / 1ps
module tsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [tsc_pkg::OUT_WIDTH-1:0]       rsp_letter_count,
   input logic [tsc_pkg::OUT_WIDTH-1:0]       rsp_digit_count,
   input logic [tsc_pkg::OUT_WIDTH-1:0]       rsp_space_count,
   input logic [tsc_pkg::OUT_WIDTH-1:0]       rsp_total_count,
   input logic [tsc_pkg::OUT_WIDTH-1:0]       rsp_matched_lines
);
   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   // Every byte transfer yields a result in the next cycle.
   a_xfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("no result after byte transfer");

   // Counts move only on a byte transfer.
   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> ($stable(rsp_total_count) && $stable(rsp_letter_count) &&
                     $stable(rsp_digit_count) && $stable(rsp_space_count) &&
                     $stable(rsp_matched_lines)))
      else $error("counts changed without a byte transfer");

   // Input is held off only while a result is stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // Reset empties the result and clears the total and matched-line counts.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && (rsp_total_count == '0) && (rsp_matched_lines == '0)))
      else $error("state not cleared by reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");
endmodule

bind text_statistics_substring_counter_core tsc_checker u_tsc_checker (.*);
